>>> rtl/core/threshold_burst_detector_macros.svh
// Assertion macros for the burst detector RTL, used by tbd_core.
`ifndef THRESHOLD_BURST_DETECTOR_MACROS_SVH
`define THRESHOLD_BURST_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define TBD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset.
`define TBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/tbd_pkg.sv
// Types and constants shared by the burst detector files.
package tbd_pkg;

   localparam int SampleBits = 16;
   localparam int IndexBits  = 21;
   // record length at which the last sample is forced as record end
   localparam logic [31:0] MaxSamples = 32'd1048576;

   typedef logic signed [SampleBits-1:0] sample_type;
   typedef logic [IndexBits-1:0]         index_type;

   typedef struct packed {
      index_type start_index;
      index_type end_index;
      logic      last_in_run;
   } result_type;

   // up to two results per request; second implies first
   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } result_push_type;

endpackage

>>> rtl/core/tbd_req_if.sv
// Request channel: one sample per request.
interface tbd_req_if import tbd_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       end_of_record;

   modport source (output valid, sample, end_of_record, input ready);
   modport sink (input valid, sample, end_of_record, output ready);
endinterface

>>> rtl/core/tbd_rsp_if.sv
// Result channel: one burst start/end pair per transfer.
interface tbd_rsp_if import tbd_pkg::*; ();
   logic      valid;
   logic      ready;
   index_type start_index;
   index_type end_index;
   logic      last_in_run;

   modport source (output valid, start_index, end_index, last_in_run, input ready);
   modport sink (input valid, start_index, end_index, last_in_run, output ready);
endinterface

>>> rtl/core/tbd_core.sv
// Input register, threshold register and burst detection state.
`include "threshold_burst_detector_macros.svh"

module tbd_core import tbd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  sample_type      csr_write_data,
   tbd_req_if.sink         req_chan,
   input  logic            push_room,
   output result_push_type push
);

   // input register
   logic       s1_valid_ff, s1_valid_in;
   sample_type s1_sample_ff;
   logic       s1_eor_ff;

   sample_type threshold_ff;

   // record state
   sample_type previous_sample_ff, previous_sample_in;
   index_type  sample_count_ff, sample_count_in;
   logic       in_burst_ff, in_burst_in;
   index_type  open_start_ff, open_start_in;
   index_type  last_nonrising_ff, last_nonrising_in;
   logic       end_pending_ff, end_pending_in;
   index_type  pending_start_ff, pending_start_in;

   logic                        advance;
   logic                        accept;
   logic                        have_prev;
   logic                        last_flag;
   logic signed [SampleBits:0]  diff;
   index_type                   idx_k;
   index_type                   idx_len;

   // per-step values before the record-end clear
   logic       step_in_burst;
   index_type  step_open_start;
   index_type  step_last_nonrising;
   logic       step_end_pending;
   index_type  step_pending_start;
   result_push_type push_raw;

   assign advance        = s1_valid_ff && push_room;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_chan.sample;
         s1_eor_ff    <= req_chan.end_of_record;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   // count never wraps: the record is cut at MaxSamples
   assign have_prev = (sample_count_ff != '0);
   assign diff      = {s1_sample_ff[SampleBits-1], s1_sample_ff}
                    - {previous_sample_ff[SampleBits-1], previous_sample_ff};
   assign idx_k     = sample_count_ff - 1'b1;
   assign idx_len   = sample_count_ff + 1'b1;
   assign last_flag = s1_eor_ff || ((32'(sample_count_ff) + 32'd1) >= MaxSamples);

   always_comb begin
      step_in_burst       = in_burst_ff;
      step_open_start     = open_start_ff;
      step_last_nonrising = last_nonrising_ff;
      step_end_pending    = end_pending_ff;
      step_pending_start  = pending_start_ff;
      push_raw            = '0;

      if (have_prev) begin
         // pending end stops at first non-falling step
         if (step_end_pending && !diff[SampleBits]) begin
            push_raw.first_valid       = 1'b1;
            push_raw.first.start_index = step_pending_start;
            push_raw.first.end_index   = idx_k;
            step_end_pending           = 1'b0;
         end
         if (diff[SampleBits] || diff == '0) begin
            step_last_nonrising = idx_k;
         end
         if (step_in_burst) begin
            if (previous_sample_ff < threshold_ff && diff[SampleBits]) begin
               step_in_burst      = 1'b0;
               step_end_pending   = 1'b1;
               step_pending_start = step_open_start;
            end
         end else if (previous_sample_ff > threshold_ff && !diff[SampleBits]
                      && diff != '0) begin
            step_in_burst   = 1'b1;
            step_open_start = step_last_nonrising;
         end
      end

      if (last_flag) begin
         if (step_end_pending) begin
            if (push_raw.first_valid) begin
               push_raw.second_valid       = 1'b1;
               push_raw.second.start_index = step_pending_start;
               push_raw.second.end_index   = sample_count_ff;
            end else begin
               push_raw.first_valid       = 1'b1;
               push_raw.first.start_index = step_pending_start;
               push_raw.first.end_index   = sample_count_ff;
            end
         end
         if (step_in_burst) begin
            if (push_raw.first_valid) begin
               push_raw.second_valid       = 1'b1;
               push_raw.second.start_index = step_open_start;
               push_raw.second.end_index   = idx_len;
            end else begin
               push_raw.first_valid       = 1'b1;
               push_raw.first.start_index = step_open_start;
               push_raw.first.end_index   = idx_len;
            end
         end
      end

      if (push_raw.second_valid) begin
         push_raw.second.last_in_run = 1'b1;
      end else if (push_raw.first_valid) begin
         push_raw.first.last_in_run = 1'b1;
      end

      push_raw.first_valid  = push_raw.first_valid && advance;
      push_raw.second_valid = push_raw.second_valid && advance;
   end

   assign push = push_raw;

   always_comb begin
      previous_sample_in = previous_sample_ff;
      sample_count_in    = sample_count_ff;
      in_burst_in        = in_burst_ff;
      open_start_in      = open_start_ff;
      last_nonrising_in  = last_nonrising_ff;
      end_pending_in     = end_pending_ff;
      pending_start_in   = pending_start_ff;
      if (advance) begin
         if (last_flag) begin
            previous_sample_in = '0;
            sample_count_in    = '0;
            in_burst_in        = 1'b0;
            open_start_in      = '0;
            last_nonrising_in  = '0;
            end_pending_in     = 1'b0;
            pending_start_in   = '0;
         end else begin
            previous_sample_in = s1_sample_ff;
            sample_count_in    = idx_len;
            in_burst_in        = step_in_burst;
            open_start_in      = step_open_start;
            last_nonrising_in  = step_last_nonrising;
            end_pending_in     = step_end_pending;
            pending_start_in   = step_pending_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_sample_ff <= '0;
         sample_count_ff    <= '0;
         in_burst_ff        <= 1'b0;
         open_start_ff      <= '0;
         last_nonrising_ff  <= '0;
         end_pending_ff     <= 1'b0;
         pending_start_ff   <= '0;
      end else begin
         previous_sample_ff <= previous_sample_in;
         sample_count_ff    <= sample_count_in;
         in_burst_ff        <= in_burst_in;
         open_start_ff      <= open_start_in;
         last_nonrising_ff  <= last_nonrising_in;
         end_pending_ff     <= end_pending_in;
         pending_start_ff   <= pending_start_in;
      end
   end

   `TBD_ASSERT_IMPL(a_burst_or_pending, 1'b1, !(in_burst_ff && end_pending_ff), "open burst with pending end")
   `TBD_ASSERT_NEXT(a_record_cleared, advance && last_flag, (sample_count_ff == '0) && !in_burst_ff && !end_pending_ff, "record state not cleared")
   `TBD_ASSERT_IMPL(a_push_order, push.second_valid, push.first_valid && !push.first.last_in_run && push.second.last_in_run, "bad result order")
   `TBD_ASSERT_IMPL(a_count_bound, 1'b1, (32'(sample_count_ff) < MaxSamples), "sample count past limit")

endmodule

>>> rtl/core/tbd_result_fifo.sv
// Result queue: takes up to two results a cycle, hands out one while rsp ready is high.
module tbd_result_fifo import tbd_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  result_push_type push,
   output logic            push_room,
   tbd_rsp_if.source       rsp_chan
);

   localparam int PtrBits   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountBits = $clog2(DEPTH + 1);

   result_type mem_ff [DEPTH];

   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [PtrBits-1:0]   wr_addr_second;
   logic                 pop;
   result_type           head;

   function automatic logic [PtrBits-1:0] ptr_inc(input logic [PtrBits-1:0] p);
      return (p == PtrBits'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // room for a full two-result request, judged before this cycle's pop
   assign push_room = (count_ff <= CountBits'(DEPTH - 2));

   assign head                 = mem_ff[rd_ptr_ff];
   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.start_index = head.start_index;
   assign rsp_chan.end_index   = head.end_index;
   assign rsp_chan.last_in_run = head.last_in_run;
   assign pop                  = rsp_chan.valid && rsp_chan.ready;
   assign wr_addr_second       = ptr_inc(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.second_valid) begin
         wr_ptr_in = ptr_inc(wr_addr_second);
      end else if (push.first_valid) begin
         wr_ptr_in = wr_addr_second;
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CountBits'(push.first_valid) + CountBits'(push.second_valid)
                - CountBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         mem_ff[wr_addr_second] <= push.second;
      end
   end

endmodule

>>> rtl/core/threshold_burst_detector.sv
// A request is held in the input register; its results go to the result queue and out on rsp.
// A request with two results shows the second once the first has been taken.
// Throughput: one request per cycle, bounded by the result port (one result a cycle)
// and by the result queue, which takes a request only with room for two results.
// Reset (synchronous, high) clears the threshold, the record state and the queue.
module threshold_burst_detector import tbd_pkg::*; #(
   parameter int RESULT_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  sample_type csr_write_data,
   tbd_req_if.sink    req_chan,
   tbd_rsp_if.source  rsp_chan
);

   // Flow: request register -> detection step (compares and one subtract
   // against the previous sample) -> result queue -> rsp.
   result_push_type push;
   logic            push_room;

   // Detection: holds the threshold, the previous sample, the sample index,
   // the open burst start and any close that still waits for its end.
   tbd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .push_room        (push_room),
      .push             (push)
   );

   // Result queue: parts the request side from a stalled result side.
   tbd_result_fifo #(
      .DEPTH (RESULT_DEPTH)
   ) u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_room (push_room),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> tb/tb_threshold_burst_detector.sv
// Self-checking testbench for threshold_burst_detector, with its burst scoreboard.
`timescale 1ns / 1ps

class burst_scoreboard;
   // threshold register and record state, mirrored from the block's behaviour
   tbd_pkg::sample_type threshold;
   tbd_pkg::sample_type prev_sample;
   logic                have_prev;
   tbd_pkg::index_type  next_index;
   logic                in_burst;
   tbd_pkg::index_type  open_start;
   tbd_pkg::index_type  last_flat;
   logic                end_pending;
   tbd_pkg::index_type  pending_start;

   tbd_pkg::result_type expected_bursts[$];
   tbd_pkg::result_type run_bursts[$];
   int                  failures;

   function new();
      threshold = '0;
      failures  = 0;
      clear_record();
   endfunction

   function void clear_record();
      prev_sample   = '0;
      have_prev     = 1'b0;
      next_index    = '0;
      in_burst      = 1'b0;
      open_start    = '0;
      last_flat     = '0;
      end_pending   = 1'b0;
      pending_start = '0;
   endfunction

   function void set_threshold(tbd_pkg::sample_type value);
      threshold = value;
   endfunction

   function int outstanding();
      return expected_bursts.size();
   endfunction

   function void emit(tbd_pkg::index_type s, tbd_pkg::index_type e);
      tbd_pkg::result_type r;
      r.start_index = s;
      r.end_index   = e;
      r.last_in_run = 1'b0;
      run_bursts.insert(run_bursts.size(), r);
   endfunction

   // One accepted request: update the record state, queue the bursts it reports.
   function void note_sample(tbd_pkg::sample_type cur, logic end_mark);
      tbd_pkg::result_type r;
      tbd_pkg::index_type  k;
      tbd_pkg::index_type  len;
      int                  d;
      logic                closing;
      run_bursts.delete();
      closing = end_mark || (int'(next_index) + 1 >= int'(tbd_pkg::MaxSamples));
      if (have_prev) begin
         k = next_index - 1'b1;
         d = int'(cur) - int'(prev_sample);
         if (end_pending && d >= 0) begin
            emit(pending_start, k);
            end_pending = 1'b0;
         end
         if (d <= 0) last_flat = k;
         if (in_burst) begin
            if (prev_sample < threshold && d < 0) begin
               in_burst      = 1'b0;
               end_pending   = 1'b1;
               pending_start = open_start;
            end
         end else if (prev_sample > threshold && d > 0) begin
            in_burst   = 1'b1;
            open_start = last_flat;
         end
      end
      len         = next_index + 1'b1;
      prev_sample = cur;
      have_prev   = 1'b1;
      next_index  = len;
      if (closing) begin
         if (end_pending && run_bursts.size() < 2) emit(pending_start, len - 1'b1);
         if (in_burst && run_bursts.size() < 2) emit(open_start, len);
         clear_record();
      end
      foreach (run_bursts[i]) begin
         r = run_bursts[i];
         r.last_in_run = (i == run_bursts.size() - 1);
         expected_bursts.insert(expected_bursts.size(), r);
      end
   endfunction

   function void check_burst(tbd_pkg::index_type s, tbd_pkg::index_type e, logic l);
      tbd_pkg::result_type want;
      if (expected_bursts.size() == 0) begin
         $error("unexpected burst: start_index %0d end_index %0d last_in_run %0b", s, e, l);
         failures++;
         return;
      end
      want = expected_bursts.pop_front();
      if (s !== want.start_index) begin
         $error("start_index: expected %0d, actual %0d", want.start_index, s);
         failures++;
      end
      if (e !== want.end_index) begin
         $error("end_index: expected %0d, actual %0d", want.end_index, e);
         failures++;
      end
      if (l !== want.last_in_run) begin
         $error("last_in_run: expected %0b, actual %0b", want.last_in_run, l);
         failures++;
      end
   endfunction

   function void flag_leftover();
      if (expected_bursts.size() != 0) begin
         $error("%0d expected bursts never arrived", expected_bursts.size());
         failures += expected_bursts.size();
      end
   endfunction
endclass

module tb_threshold_burst_detector;
   import tbd_pkg::*;

   // Record shapes for the random part. Waves cross the threshold in both
   // directions and make most of the bursts; levels sit on the threshold with
   // many equal neighbours; noise is unstructured, short records.
   typedef enum int {SHAPE_WAVE, SHAPE_LEVELS, SHAPE_NOISE} record_shape_type;

   // Eight random phases of at least PhaseRequests requests plus the directed records;
   // the watchdog allows for two bursts per request under the longest receiver stalls.
   localparam int WatchdogCycles = 400_000;
   // Cycles allowed for a request that causes no burst to leave the pipeline.
   localparam int SettleCycles   = 10;
   localparam int PhaseRequests  = 95;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   sample_type csr_write_data;

   tbd_req_if req_chan ();
   tbd_rsp_if rsp_chan ();

   threshold_burst_detector dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   burst_scoreboard sb;
   int              burst_left;
   logic            pace_requests;
   int              phase_requests;
   int              current_threshold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: its own stall pattern, mostly short stalls, now and then a long
   // one, and long stretches of solid ready so back-to-back results are seen.
   initial begin
      int   hold;
      logic level;
      rsp_chan.ready = 1'b0;
      hold  = 0;
      level = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  level = 1'b0;
                  hold  = $urandom_range(1, 5);
               end
               3: begin
                  level = 1'b0;
                  hold  = $urandom_range(6, 20);
               end
               4: begin
                  level = 1'b1;
                  hold  = $urandom_range(40, 120);
               end
               default: begin
                  level = 1'b1;
                  hold  = $urandom_range(1, 8);
               end
            endcase
         end
         rsp_chan.ready <= level;
         hold--;
      end
   end

   // Every accepted burst is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         sb.check_burst(rsp_chan.start_index, rsp_chan.end_index, rsp_chan.last_in_run);
   end

   initial begin
      repeat (WatchdogCycles) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   // One sample request. With pacing on, the sender works in bursts of
   // random length with random gaps of valid low between them.
   task automatic send_sample(sample_type s, logic end_mark);
      int gap;
      if (pace_requests && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_chan.valid         <= 1'b1;
      req_chan.sample        <= s;
      req_chan.end_of_record <= end_mark;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_sample(s, end_mark);
      phase_requests++;
      if (burst_left > 0) burst_left--;
   endtask

   task automatic send_list(int vals[$]);
      foreach (vals[i]) send_sample(sample_type'(vals[i]), i == vals.size() - 1);
   endtask

   function automatic int clamp_sample(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Drop valid, wait for every expected burst and for the pipeline to empty.
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Threshold writes happen only with the block idle.
   task automatic write_threshold(int value);
      settle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= sample_type'(value);
      @(posedge clock);
      sb.set_threshold(sample_type'(value));
      current_threshold = int'(sample_type'(value));
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Ramps that swing through the threshold: opens, closes, refined start and
   // end searches, with the odd flat step and sudden reversal.
   task automatic send_wave(int len);
      int v;
      int dir;
      int span;
      int stride;
      span = $urandom_range(50, 8000);
      v    = clamp_sample(current_threshold + $urandom_range(0, 2 * span) - span);
      dir  = $urandom_range(0, 1) ? 1 : -1;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0: stride = 0;
            1: begin
               dir    = -dir;
               stride = $urandom_range(1, span);
            end
            default: stride = $urandom_range(1, span / 3 + 1);
         endcase
         v = v + dir * stride;
         if (v > current_threshold + span) dir = -1;
         if (v < current_threshold - span) dir = 1;
         if (v > 32767 || v < -32768) begin
            v   = clamp_sample(v);
            dir = -dir;
         end
         send_sample(sample_type'(v), i == len - 1);
      end
   endtask

   task automatic send_levels(int len);
      for (int i = 0; i < len; i++)
         send_sample(sample_type'(clamp_sample(current_threshold + $urandom_range(0, 4) - 2)),
                     i == len - 1);
   endtask

   task automatic send_noise(int len);
      for (int i = 0; i < len; i++)
         send_sample(sample_type'($urandom_range(0, 65535)), i == len - 1);
   endtask

   task automatic random_phase(int requests);
      record_shape_type shape;
      int               pick;
      int               len;
      phase_requests = 0;
      while (phase_requests < requests) begin
         pick = $urandom_range(0, 19);
         shape = (pick < 14) ? SHAPE_WAVE : (pick < 17) ? SHAPE_LEVELS : SHAPE_NOISE;
         case (shape)
            SHAPE_WAVE: begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(2, 40);
               send_wave(len);
            end
            SHAPE_LEVELS: send_levels($urandom_range(2, 20));
            default:      send_noise($urandom_range(1, 8));
         endcase
      end
   endtask

   initial begin
      int directed[$];
      int phase_thresholds[$];
      sb                     = new();
      burst_left             = 0;
      pace_requests          = 1'b1;
      current_threshold      = 0;
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_write_data         = '0;
      req_chan.valid         = 1'b0;
      req_chan.sample        = '0;
      req_chan.end_of_record = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed records at the reset threshold of zero.
      // Single-sample record: nothing may come out.
      directed = {7};
      send_list(directed);
      // Field extremes, a flat step inside the burst, a close, and a pending
      // end released by the next rise.
      directed = {-32768, 100, 200, 200, -5, -50, -40, 32767};
      send_list(directed);
      // Samples equal to the threshold must neither open nor close.
      directed = {0, 0, 5, 0, -3, 0};
      send_list(directed);
      // Burst still open at record end: end is the record length.
      directed = {-1, 10, 20, 30};
      send_list(directed);
      // Pending end at record end: end is the last index.
      directed = {20, 30, -10, -20};
      send_list(directed);

      // Random phases across threshold settings, extremes first.
      phase_thresholds = {32767, -32768, 0, int'($urandom_range(0, 65535)),
                          $urandom_range(0, 400) - 200, int'($urandom_range(0, 65535)),
                          $urandom_range(0, 4000) - 2000, 0};
      foreach (phase_thresholds[i]) begin
         write_threshold(phase_thresholds[i]);
         random_phase(PhaseRequests);
      end

      settle();
      sb.flag_leftover();
      if (sb.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> threshold_burst_detector.f
+incdir+rtl/core
rtl/core/tbd_pkg.sv
rtl/core/tbd_req_if.sv
rtl/core/tbd_rsp_if.sv
rtl/core/tbd_core.sv
rtl/core/tbd_result_fifo.sv
rtl/core/threshold_burst_detector.sv
tb/tb_threshold_burst_detector.sv
